// ===== hdl/bfknn_pkg.sv =====
// bfknn_pkg: constants, types and codes for the knn select core
// no dependencies
`default_nettype none
package bfknn_pkg;
  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned MaxDims = 64;
  localparam int unsigned MaxNeighbours = 64;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned PtBits = $clog2(MaxPoints);
  localparam int unsigned DimBits = $clog2(MaxDims);
  localparam int unsigned RankBits = $clog2(MaxNeighbours);
  localparam int unsigned DistBits = 38;
  localparam int unsigned StoreAw = PtBits + DimBits;

  localparam logic [1:0] RegPointCount = 2'd0;
  localparam logic [1:0] RegDimCount = 2'd1;
  localparam logic [1:0] RegNeighbourCount = 2'd2;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StQload = 6'b000010,
    StDist  = 6'b000100,
    StSel   = 6'b001000,
    StEmit  = 6'b010000,
    StWait  = 6'b100000
  } state_e;
endpackage
`default_nettype wire

// ===== hdl/bfknn_mac.sv =====
// bfknn_mac: shared subtract / square / accumulate unit, two stages
// depends on bfknn_pkg
`default_nettype none
module bfknn_mac import bfknn_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clr_i,
  input  wire logic                        en_i,
  input  wire logic signed [CoordBits-1:0] a_i,
  input  wire logic signed [CoordBits-1:0] b_i,
  output logic         [DistBits-1:0]      acc_o
);
  logic signed [CoordBits:0] diff_q;
  logic                      vld_q;
  logic [2*CoordBits+1:0]    sq;
  logic [DistBits-1:0]       acc_q;

  assign sq = $unsigned((2*CoordBits+2)'(diff_q) * (2*CoordBits+2)'(diff_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      acc_q <= '0;
    end else begin
      vld_q <= en_i;
      if (clr_i) begin
        acc_q <= '0;
      end else if (vld_q) begin
        acc_q <= acc_q + DistBits'(sq);
      end
    end
  end

  // diff registered before the multiply
  always_ff @(posedge clk_i) begin
    diff_q <= {a_i[CoordBits-1], a_i} - {b_i[CoordBits-1], b_i};
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

// ===== hdl/brute_force_knn_select_core.sv =====
// brute_force_knn_select_core: top level of the brute-force knn selector
// depends on bfknn_pkg and bfknn_mac
// throughput: one beat at a time, busy high while a query runs
// rate set by the single mac unit and one scratch read port per cycle
// reset clears control and presets config; store, query copy and scratch stay undefined
// results are strobed one cycle each, the receiver cannot stall
`default_nettype none
module brute_force_knn_select_core import bfknn_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [10:0]          cfg_data_i,
  input  wire logic                 cmd_i,
  input  wire logic [PtBits-1:0]    point_index_i,
  input  wire logic [DimBits-1:0]   dim_index_i,
  input  wire logic signed [CoordBits-1:0] coord_value_i,
  output logic                      res_valid_o,
  output logic [PtBits-1:0]         neighbour_index_o,
  output logic [DistBits-1:0]       squared_distance_o,
  output logic [RankBits-1:0]       rank_o,
  output logic                      last_o
);
  state_e st_q, st_d;

  logic [10:0] npts_q;
  logic [6:0]  ndim_q, nnb_q;

  // point store, query copy and scratch
  logic signed [CoordBits-1:0] store_mem [2**StoreAw];
  logic signed [CoordBits-1:0] qry_mem [MaxDims];
  logic signed [CoordBits-1:0] st_rd_q, qry_rd_q;
  logic [DistBits-1:0] scr_mem [MaxPoints];
  logic [DistBits-1:0] scr_rd_q;

  logic [PtBits-1:0] qpt_q;
  logic [10:0] pt_q;     // point counter, also holds n
  logic [6:0]  dm_q;     // dimension counter
  logic [1:0]  tail_q;   // mac drain
  logic [6:0]  k_q;
  logic [RankBits-1:0] rank_q;
  logic [PtBits-1:0] best_q;
  logic [DistBits-1:0] bestd_q;
  logic [PtBits-1:0] prev_q;     // last emitted neighbour
  logic [DistBits-1:0] prevd_q;
  logic found_q;
  logic rd_vld_q;
  logic [PtBits-1:0] rd_pt_q;

  logic [10:0] n_eff;
  logic [6:0]  d_eff, k_eff, kclamp;
  logic mac_clr, mac_en;
  logic [DistBits-1:0] acc;
  logic accept;
  logic elig;

  assign accept = start && !busy;
  assign busy = (st_q != StIdle);
  assign n_eff = (npts_q > 11'(MaxPoints)) ? 11'(MaxPoints) : npts_q;
  assign d_eff = (ndim_q > 7'(MaxDims)) ? 7'(MaxDims) : ndim_q;
  assign k_eff = (nnb_q > 7'(MaxNeighbours)) ? 7'(MaxNeighbours) : nnb_q;
  assign kclamp = ({4'd0, k_eff} > n_eff - 11'd1) ? 7'(n_eff - 11'd1) : k_eff;

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      npts_q <= 11'd1024;
      ndim_q <= 7'd64;
      nnb_q  <= 7'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPointCount:     npts_q <= cfg_data_i;
        RegDimCount:       ndim_q <= cfg_data_i[6:0];
        RegNeighbourCount: nnb_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // store write on load beats, reads driven by the sequencer
  logic [StoreAw-1:0] st_raddr;
  assign st_raddr = (st_q == StQload) ? {qpt_q, dm_q[DimBits-1:0]}
                                      : {pt_q[PtBits-1:0], dm_q[DimBits-1:0]};
  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == CmdLoad) begin
      store_mem[{point_index_i, dim_index_i}] <= coord_value_i;
    end
    st_rd_q  <= store_mem[st_raddr];
    qry_rd_q <= qry_mem[dm_q[DimBits-1:0]];
  end

  // query copy written in the cycle after the store read
  logic qw_q;
  logic [DimBits-1:0] qw_a_q;
  always_ff @(posedge clk_i) begin
    qw_a_q <= dm_q[DimBits-1:0];
    if (qw_q) qry_mem[qw_a_q] <= st_rd_q;
  end

  // scratch memory, written at end of each distance, read while selecting
  logic scr_we;
  logic [PtBits-1:0] scr_wa;
  assign scr_we = (st_q == StDist) && (tail_q == 2'd3);
  assign scr_wa = pt_q[PtBits-1:0];
  always_ff @(posedge clk_i) begin
    if (scr_we) scr_mem[scr_wa] <= acc;
    scr_rd_q <= scr_mem[pt_q[PtBits-1:0]];
  end

  assign mac_clr = (st_q == StDist) && (tail_q == 2'd3);
  assign mac_en  = (st_q == StDist) && (tail_q == 2'd0) && rd_vld_q;

  bfknn_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (mac_clr || accept),
    .en_i   (mac_en),
    .a_i    (qry_rd_q),
    .b_i    (st_rd_q),
    .acc_o  (acc)
  );

  // a candidate must come after the last emitted neighbour in nearest-first
  // order: larger distance, or equal distance and lower index; the query
  // point itself never takes part
  assign elig = (rd_pt_q != qpt_q) &&
                ((rank_q == '0) || (scr_rd_q > prevd_q) ||
                 ((scr_rd_q == prevd_q) && (rd_pt_q < prev_q)));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: begin
        if (accept && cmd_i == CmdQuery) begin
          if (n_eff >= 11'd2 && {1'b0, point_index_i} < n_eff && kclamp != 7'd0) begin
            st_d = StQload;
          end
        end
      end
      StQload: if (dm_q == d_eff + 7'd1) st_d = StDist;
      StDist:  if (tail_q == 2'd3 && pt_q == n_eff - 11'd1) st_d = StSel;
      StSel:   if (pt_q == n_eff + 11'd1) st_d = StEmit;
      StEmit:  st_d = (7'(rank_q) + 7'd1 == k_q) ? StIdle : StWait;
      StWait:  st_d = StSel;
      default: st_d = StIdle;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      pt_q <= '0; dm_q <= '0; tail_q <= '0; k_q <= '0; rank_q <= '0;
      qpt_q <= '0; found_q <= 1'b0; rd_vld_q <= 1'b0; qw_q <= 1'b0;
      best_q <= '0; bestd_q <= '0; rd_pt_q <= '0;
      prev_q <= '0; prevd_q <= '0;
      res_valid_o <= 1'b0;
      neighbour_index_o <= '0;
      squared_distance_o <= '0;
      rank_o <= '0;
      last_o <= 1'b0;
    end else begin
      st_q <= st_d;
      res_valid_o <= (st_q == StEmit);
      // copy query point while its reads return
      qw_q <= (st_q == StQload) && (dm_q < d_eff);
      unique case (st_q)
        StIdle: begin
          qpt_q <= point_index_i;
          k_q <= kclamp;
          dm_q <= '0;
          pt_q <= '0;
          rank_q <= '0;
          tail_q <= '0;
          rd_vld_q <= 1'b0;
        end
        StQload: begin
          dm_q <= (st_d == StDist) ? 7'd0 : dm_q + 7'd1;
        end
        StDist: begin
          if (tail_q == 2'd0) begin
            rd_vld_q <= (dm_q != d_eff);
            if (dm_q == d_eff) begin
              tail_q <= 2'd1;
            end else begin
              dm_q <= dm_q + 7'd1;
            end
          end else if (tail_q == 2'd3) begin
            tail_q <= 2'd0;
            dm_q <= '0;
            rd_vld_q <= 1'b0;
            pt_q <= (st_d == StSel) ? 11'd0 : pt_q + 11'd1;
            if (st_d == StSel) begin
              found_q <= 1'b0;
            end
          end else begin
            rd_vld_q <= 1'b0;
            tail_q <= tail_q + 2'd1;
          end
        end
        StSel: begin
          // one scratch read a cycle, compared in the cycle after
          rd_pt_q <= pt_q[PtBits-1:0];
          rd_vld_q <= (pt_q < n_eff);
          pt_q <= pt_q + 11'd1;
          if (rd_vld_q && elig && (!found_q || scr_rd_q <= bestd_q)) begin
            best_q <= rd_pt_q;
            bestd_q <= scr_rd_q;
            found_q <= 1'b1;
          end
        end
        StEmit: begin
          neighbour_index_o <= best_q;
          squared_distance_o <= bestd_q;
          rank_o <= rank_q;
          last_o <= (7'(rank_q) + 7'd1 == k_q);
          prev_q <= best_q;
          prevd_q <= bestd_q;
          rank_q <= rank_q + RankBits'(1);
          pt_q <= '0;
          found_q <= 1'b0;
          rd_vld_q <= 1'b0;
        end
        StWait: begin
          pt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // results only strobe after an emit state, the last one with the core already idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(st_q == StEmit)) else $error("stray result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_o) |-> !busy) else $error("busy after last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StEmit) |-> found_q) else $error("emit without pick");
endmodule
`default_nettype wire

// ===== verif/tb_brute_force_knn_select_core.sv =====
// testbench for brute_force_knn_select_core: loads point sets, runs neighbour queries
// and checks every strobed neighbour beat against an in-bench nearest-first predictor
// depends on bfknn_pkg and the core rtl
`timescale 1ns / 1ps
module tb_brute_force_knn_select_core import bfknn_pkg::*; ();

  // index past the register list, written to show it is ignored
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [PtBits-1:0]   nbr;
    logic [DistBits-1:0] sqd;
    logic [RankBits-1:0] rank;
    logic                last;
  } nbr_beat_t;

  typedef enum logic {RowCfg, RowItem} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [1:0]        reg_idx;
    logic [10:0]       reg_val;
    logic              cmd;
    int unsigned       pidx;
    int unsigned       didx;
    int                coord;
    bit                typed;     // expected beat typed in below
    int unsigned       exp_nbr;
    longint unsigned   exp_dist;
  } stim_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic                        cfg_we_i;
  logic [1:0]                  cfg_idx_i;
  logic [10:0]                 cfg_data_i;
  logic                        cmd_i;
  logic [PtBits-1:0]           point_index_i;
  logic [DimBits-1:0]          dim_index_i;
  logic signed [CoordBits-1:0] coord_value_i;
  logic                        res_valid_o;
  logic [PtBits-1:0]           neighbour_index_o;
  logic [DistBits-1:0]         squared_distance_o;
  logic [RankBits-1:0]         rank_o;
  logic                        last_o;

  brute_force_knn_select_core dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i, .point_index_i, .dim_index_i, .coord_value_i,
    .res_valid_o, .neighbour_index_o, .squared_distance_o, .rank_o, .last_o
  );

  // predictor state: coordinate store and the raw register values
  logic signed [CoordBits-1:0] coord_mem [MaxPoints][MaxDims];
  logic [10:0] cfg_points;
  logic [6:0]  cfg_dims;
  logic [6:0]  cfg_nbrs;

  nbr_beat_t   pending_nbrs[$];   // neighbour beats still owed by the core
  int unsigned mismatch_count;
  int unsigned next_gap;          // idle cycles before the next beat
  bit          burst_mode;        // no idling between beats while set

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("tb_brute_force_knn_select_core NOT OK");
    $finish;
  end

  // expected neighbours of one query: distances to every point, then k
  // selection passes, ties resolved toward the higher point index
  task automatic predict_neighbours(input int unsigned qp);
    longint unsigned dist_tab [MaxPoints];
    bit              taken [MaxPoints];
    int unsigned     n, d, k, best;
    bit              found;
    longint          diff;
    nbr_beat_t       b;
    n = (cfg_points > MaxPoints) ? MaxPoints : cfg_points;
    d = (cfg_dims > MaxDims) ? MaxDims : cfg_dims;
    k = (cfg_nbrs > MaxNeighbours) ? MaxNeighbours : cfg_nbrs;
    if (n < 2 || qp >= n) return;
    if (k > n - 1) k = n - 1;
    for (int j = 0; j < n; j++) begin
      dist_tab[j] = 0;
      taken[j] = 1'b0;
      for (int c = 0; c < d; c++) begin
        diff = longint'(coord_mem[qp][c]) - longint'(coord_mem[j][c]);
        dist_tab[j] += diff * diff;
      end
    end
    taken[qp] = 1'b1;
    for (int r = 0; r < k; r++) begin
      found = 1'b0;
      best = 0;
      for (int j = 0; j < n; j++) begin
        if (!taken[j] && (!found || dist_tab[j] <= dist_tab[best])) begin
          best = j;
          found = 1'b1;
        end
      end
      taken[best] = 1'b1;
      b.nbr = PtBits'(best);
      b.sqd = DistBits'(dist_tab[best]);
      b.rank = RankBits'(r);
      b.last = (r + 1 == k);
      pending_nbrs.push_back(b);
    end
  endtask

  // one command beat: idle gap, hold start until the core takes it, then
  // update the predictor; start is dropped in the accept step unless the
  // next beat follows at once
  task automatic send_beat(input logic cmd, input int unsigned pidx,
                           input int unsigned didx, input int coord,
                           input bit typed = 1'b0, input nbr_beat_t typed_beat = '0);
    repeat (next_gap) @(posedge clk_i);
    start <= 1'b1;
    cmd_i <= cmd;
    point_index_i <= PtBits'(pidx);
    dim_index_i <= DimBits'(didx);
    coord_value_i <= CoordBits'(coord);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (cmd == CmdLoad) coord_mem[PtBits'(pidx)][DimBits'(didx)] = CoordBits'(coord);
    else if (typed) pending_nbrs.push_back(typed_beat);
    else predict_neighbours(pidx);
    next_gap = burst_mode ? 0 : $urandom_range(0, 6);
    if (next_gap != 0) start <= 1'b0;
  endtask

  // wait for every owed beat, the core idle, and a short settle
  task automatic drain;
    if (next_gap == 0) start <= 1'b0;
    next_gap = 1;
    @(posedge clk_i);
    while (pending_nbrs.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegPointCount:     cfg_points = val;
      RegDimCount:       cfg_dims = val[6:0];
      RegNeighbourCount: cfg_nbrs = val[6:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic int draw_coord();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // one setting: program it, fill every coordinate a query will read,
  // then queries mixed with overwrites and out-of-range noise
  task automatic run_setting(input int unsigned n, input int unsigned d,
                             input int unsigned k, input int unsigned queries,
                             input bit corner_fill);
    drain();
    write_reg(RegPointCount, 11'(n));
    write_reg(RegDimCount, 11'(d));
    write_reg(RegNeighbourCount, 11'(k));
    burst_mode = ($urandom_range(0, 3) == 0);
    for (int p = 0; p < n; p++)
      for (int c = 0; c < d; c++)
        send_beat(CmdLoad, p, c, corner_fill ? ((p == 0) ? -32768 : 32767) : draw_coord());
    for (int q = 0; q < queries; q++) begin
      case ($urandom_range(0, 9))
        0: send_beat(CmdLoad, $urandom_range(0, n - 1), $urandom_range(0, d - 1),
                     draw_coord());
        1: send_beat(CmdLoad, $urandom_range(0, MaxPoints - 1),
                     $urandom_range(0, MaxDims - 1), draw_coord());
        2: send_beat(CmdQuery, $urandom_range(n - 1, MaxPoints - 1), 0, 0);
        default: send_beat(CmdQuery, $urandom_range(0, n - 1),
                           $urandom, int'($signed(16'($urandom))));
      endcase
    end
  endtask

  // result checker: every strobed beat against the oldest owed beat
  always @(posedge clk_i) begin : nbr_check
    nbr_beat_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_nbrs.size() == 0) begin
        $error("unexpected neighbour beat: index %0d distance %0d",
               neighbour_index_o, squared_distance_o);
        mismatch_count++;
      end else begin
        want = pending_nbrs.pop_front();
        if (neighbour_index_o !== want.nbr) begin
          $error("neighbour_index expected %0d actual %0d", want.nbr, neighbour_index_o);
          mismatch_count++;
        end
        if (squared_distance_o !== want.sqd) begin
          $error("squared_distance expected %0d actual %0d", want.sqd, squared_distance_o);
          mismatch_count++;
        end
        if (rank_o !== want.rank) begin
          $error("rank expected %0d actual %0d", want.rank, rank_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last expected %0d actual %0d", want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // directed rows: extremes, clamps, saturation, empty queries
  stim_row_t directed [] = '{
    '{RowItem, 0, 0, CmdLoad, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegPointCount, 2, 0, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegDimCount, 1, 0, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegNeighbourCount, 1, 0, 0, 0, 0, 0, 0, 0},
    '{RowItem, 0, 0, CmdLoad, 0, 0, -32768, 0, 0, 0},
    '{RowItem, 0, 0, CmdLoad, 1, 0, 32767, 0, 0, 0},
    // opposite extremes in one coordinate
    '{RowItem, 0, 0, CmdQuery, 0, 0, 0, 1, 1, 64'd4294836225},
    '{RowItem, 0, 0, CmdQuery, 1, 63, -1, 1, 0, 64'd4294836225},
    // query point outside the configured points
    '{RowItem, 0, 0, CmdQuery, 1023, 0, 0, 0, 0, 0},
    // zero neighbours asked
    '{RowCfg, RegNeighbourCount, 0, 0, 0, 0, 0, 0, 0, 0},
    '{RowItem, 0, 0, CmdQuery, 0, 0, 0, 0, 0, 0},
    // no coordinates: all distances zero
    '{RowCfg, RegDimCount, 0, 0, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegNeighbourCount, 1, 0, 0, 0, 0, 0, 0, 0},
    '{RowItem, 0, 0, CmdQuery, 1, 0, 0, 1, 0, 0},
    // oversized registers saturate, all ties resolved by index
    '{RowCfg, RegPointCount, 11'h7ff, 0, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegNeighbourCount, 127, 0, 0, 0, 0, 0, 0, 0},
    '{RowItem, 0, 0, CmdQuery, 5, 0, 0, 0, 0, 0},
    // too few points: nothing comes back
    '{RowCfg, RegPointCount, 1, 0, 0, 0, 0, 0, 0, 0},
    '{RowItem, 0, 0, CmdQuery, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegPointCount, 0, 0, 0, 0, 0, 0, 0, 0},
    '{RowItem, 0, 0, CmdQuery, 0, 0, 0, 0, 0, 0},
    '{RowCfg, RegUnused, 11'h5a5, 0, 0, 0, 0, 0, 0, 0}
  };

  initial begin : main_seq
    nbr_beat_t tb;
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegPointCount;
    cfg_data_i = '0;
    cmd_i = CmdLoad;
    point_index_i = '0;
    dim_index_i = '0;
    coord_value_i = '0;
    mismatch_count = 0;
    next_gap = 0;
    burst_mode = 1'b0;
    cfg_points = 11'd1024;
    cfg_dims = 7'd64;
    cfg_nbrs = 7'd1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == RowCfg) begin
        drain();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        tb.nbr = PtBits'(directed[i].exp_nbr);
        tb.sqd = DistBits'(directed[i].exp_dist);
        tb.rank = '0;
        tb.last = 1'b1;
        send_beat(directed[i].cmd, directed[i].pidx, directed[i].didx,
                  directed[i].coord, directed[i].typed, tb);
      end
    end

    // two points at opposite corners over many coordinates: top distance bit set
    run_setting(2, 34, 1, 2, 1'b1);
    // a dozen points on one coordinate, k clamped to points minus one
    run_setting(12, 1, 64, 2, 1'b0);
    // small random settings, k often clamped
    repeat (2)
      run_setting($urandom_range(2, 5), $urandom_range(1, 3),
                  $urandom_range(1, 12), 4, 1'b0);

    drain();
    repeat (200) @(posedge clk_i);
    if (pending_nbrs.size() != 0) begin
      $error("%0d neighbour beats never arrived", pending_nbrs.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("tb_brute_force_knn_select_core OK");
    else
      $display("tb_brute_force_knn_select_core NOT OK");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/bfknn_pkg.sv
hdl/bfknn_mac.sv
hdl/brute_force_knn_select_core.sv
verif/tb_brute_force_knn_select_core.sv
